// File: hdl/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Types and constants shared by the key macro sequencer.
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam int MAX_STEPS = 8;
	localparam int PTR_W     = 3;  // width of load_slot and step_number
	localparam int CNT_W     = 4;  // width of step_count

	// operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_HELD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 2'd2;

	typedef struct packed {
		logic             operation;
		logic [31:0]      now_ms;
		logic             trigger_down;
		logic [31:0]      trigger_presses;
		logic [PTR_W-1:0] load_slot;
		logic [8:0]       load_key;
		logic [15:0]      load_delay_ms;
	} kms_in_t;

	typedef struct packed {
		logic [8:0]       send_key;
		logic [PTR_W-1:0] step_number;
	} kms_out_t;

endpackage

// File: hdl/key_macro_sequencer.sv
// ----------------------------------------------------------------------------
// key_macro_sequencer
// Plays a stored key macro of up to eight steps when a trigger key is pressed.
// ----------------------------------------------------------------------------
// Each tick word carries the millisecond time and a sample of the trigger key;
// a load word writes one step (key and delay) of the macro table. A press
// (change of the press count or a rising edge of the trigger) starts the macro
// or queues another round. A tick on which a step is due returns one word with
// the key to send and its step number. Words pass an input register and a
// result register: one word is taken every cycle except in a stall, and a word's
// result is registered as it leaves the input register. The input side stalls
// only while the result register holds an untaken word. Registers may be
// written only while the block is idle; the table must be loaded before use.
module key_macro_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kms_pkg::kms_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kms_pkg::kms_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kms_pkg::CFG_DAT_W-1:0] cfg_data
);
	import kms_pkg::*;

	// configuration
	logic [15:0]      press_len_q;
	logic             repeat_q;
	logic [CNT_W-1:0] step_count_q;

	// sequencer state
	logic [31:0]      seen_presses_q;
	logic             was_held_q;
	logic             running_q;
	logic             round_queued_q;
	logic             end_check_q;
	logic [PTR_W-1:0] step_ptr_q;
	logic [31:0]      due_q;

	logic [8:0]       step_keys_q   [MAX_STEPS];
	logic [15:0]      step_delays_q [MAX_STEPS];

	// pipeline
	logic             valid_s1;
	kms_in_t          item_s1;
	logic             res_valid_q;
	kms_out_t         res_q;
	logic             advance;

	// next-state values
	logic             running_n;
	logic             round_queued_n;
	logic             end_check_n;
	logic [PTR_W-1:0] step_ptr_n;
	logic [31:0]      due_n;
	logic             fire;
	logic [PTR_W-1:0] ptr_cur;
	logic [CNT_W-1:0] active_steps;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_len_q  <= '0;
			repeat_q     <= 1'b0;
			step_count_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRESS_LENGTH: press_len_q  <= cfg_data;
				REG_REPEAT_HELD:  repeat_q     <= cfg_data[0];
				REG_STEP_COUNT:   step_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (step_count_q == '0)
			active_steps = CNT_W'(1);
		else if (int'(step_count_q) > MAX_STEPS)
			active_steps = CNT_W'(MAX_STEPS);
		else
			active_steps = step_count_q;
	end

	always_comb begin
		logic             pressed;
		logic             go;
		logic [31:0]      due_eff;
		logic [31:0]      diff;
		logic [CNT_W-1:0] ptr_inc;
		pressed        = (item_s1.trigger_presses != seen_presses_q) ||
		                 (item_s1.trigger_down && !was_held_q);
		running_n      = running_q;
		round_queued_n = round_queued_q;
		end_check_n    = end_check_q;
		step_ptr_n     = step_ptr_q;
		due_n          = due_q;
		fire           = 1'b0;
		go             = 1'b0;
		due_eff        = due_q;
		ptr_cur        = step_ptr_q;
		ptr_inc        = '0;

		// end decision on the tick after the last step
		if (end_check_q) begin
			end_check_n = 1'b0;
			if (pressed)
				round_queued_n = 1'b1;
			pressed = 1'b0;
			if (round_queued_n)
				round_queued_n = 1'b0;
			else if (!repeat_q || !item_s1.trigger_down)
				running_n = 1'b0;
		end

		if (!running_n) begin
			if (pressed) begin
				running_n = 1'b1;
				ptr_cur   = '0;
				due_eff   = item_s1.now_ms;
				go        = 1'b1;
			end
		end else begin
			if (pressed)
				round_queued_n = 1'b1;
			go = 1'b1;
		end
		step_ptr_n = ptr_cur;
		due_n      = due_eff;

		diff = item_s1.now_ms - due_eff;
		if (go && !diff[31]) begin
			fire    = 1'b1;
			due_n   = item_s1.now_ms + 32'(press_len_q) + 32'(step_delays_q[ptr_cur]);
			ptr_inc = CNT_W'(ptr_cur) + CNT_W'(1);
			if (ptr_inc >= active_steps) begin
				step_ptr_n  = '0;
				end_check_n = 1'b1;
			end else begin
				step_ptr_n = ptr_inc[PTR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			res_valid_q    <= 1'b0;
			seen_presses_q <= '0;
			was_held_q     <= 1'b0;
			running_q      <= 1'b0;
			round_queued_q <= 1'b0;
			end_check_q    <= 1'b0;
			step_ptr_q     <= '0;
			due_q          <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				res_valid_q <= fire && (item_s1.operation == OP_TICK);
			else if (out_ready)
				res_valid_q <= 1'b0;
			if (advance && item_s1.operation == OP_TICK) begin
				seen_presses_q <= item_s1.trigger_presses;
				was_held_q     <= item_s1.trigger_down;
				running_q      <= running_n;
				round_queued_q <= round_queued_n;
				end_check_q    <= end_check_n;
				step_ptr_q     <= step_ptr_n;
				due_q          <= due_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (advance && fire && item_s1.operation == OP_TICK) begin
			res_q.send_key    <= step_keys_q[ptr_cur];
			res_q.step_number <= ptr_cur;
		end
		if (advance && item_s1.operation == OP_LOAD &&
		    int'(item_s1.load_slot) < MAX_STEPS) begin
			step_keys_q[item_s1.load_slot]   <= item_s1.load_key;
			step_delays_q[item_s1.load_slot] <= item_s1.load_delay_ms;
		end
	end

	// the end decision is only pending while a sequence runs
	a_end_check_running: assert property (@(posedge clk) disable iff (!arst_n)
		end_check_q |-> running_q)
		else $error("end check pending while idle");

	// a queued round never survives the sequence stopping
	a_queue_running: assert property (@(posedge clk) disable iff (!arst_n)
		round_queued_q |-> running_q)
		else $error("round queued while idle");

	// after the last step the pointer is back at step 0
	a_end_ptr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		end_check_q |-> (step_ptr_q == '0))
		else $error("step pointer not rewound at end of round");

endmodule

// File: tb/key_macro_sequencer_test.sv
// ----------------------------------------------------------------------------
// key_macro_sequencer_test
// Self-checking bench for the key macro sequencer. It fills the step table,
// then plays directed trigger ticks and eight randomized phases under
// different register settings and handshake idling. Each accepted word runs
// through a local copy of the macro player, and every key word that comes out
// is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module key_macro_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 4;    // idle cycles after the last key word is checked
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 98;
	localparam int IN_W        = $bits(kms_in_t);

	// Tracks the macro player state and the key words it owes.
	class macro_player;
		logic [15:0]      press_len;
		bit               repeat_held;
		logic [CNT_W-1:0] step_total;
		logic [31:0]      seen_count;
		bit               was_down;
		bit               playing;
		bit               round_waiting;
		bit               end_due;
		logic [PTR_W-1:0] cur_step;
		logic [31:0]      due_ms;
		logic [8:0]       slot_key [MAX_STEPS];
		logic [15:0]      slot_delay [MAX_STEPS];
		kms_out_t         keys_due [$];
		int               errors;

		function new();
			press_len     = '0;
			repeat_held   = 1'b0;
			step_total    = CNT_W'(1);
			seen_count    = '0;
			was_down      = 1'b0;
			playing       = 1'b0;
			round_waiting = 1'b0;
			end_due       = 1'b0;
			cur_step      = '0;
			due_ms        = '0;
			errors        = 0;
			foreach (slot_key[i]) begin
				slot_key[i]   = '0;
				slot_delay[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_PRESS_LENGTH: press_len = val;
				REG_REPEAT_HELD: repeat_held = val[0];
				REG_STEP_COUNT: step_total = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_word(kms_in_t w);
			bit           pressed;
			logic [CNT_W:0] limit;
			logic [CNT_W:0] nxt;
			logic [31:0]  gap;
			kms_out_t     k;
			if (w.operation == OP_LOAD) begin
				slot_key[w.load_slot]   = w.load_key;
				slot_delay[w.load_slot] = w.load_delay_ms;
				return;
			end
			pressed = (w.trigger_presses != seen_count) || (w.trigger_down && !was_down);
			seen_count = w.trigger_presses;
			was_down   = w.trigger_down;
			// end of round: this tick's press only feeds the queued round
			if (end_due) begin
				end_due = 1'b0;
				if (pressed)
					round_waiting = 1'b1;
				pressed = 1'b0;
				if (round_waiting)
					round_waiting = 1'b0;
				else if (!repeat_held || !w.trigger_down)
					playing = 1'b0;
			end
			if (!playing) begin
				if (!pressed)
					return;
				playing  = 1'b1;
				cur_step = '0;
				due_ms   = w.now_ms;
			end else if (pressed) begin
				round_waiting = 1'b1;
			end
			gap = w.now_ms - due_ms;
			if (gap[31])
				return;
			k.send_key    = slot_key[cur_step];
			k.step_number = cur_step;
			keys_due.push_back(k);
			due_ms = w.now_ms + press_len + slot_delay[cur_step];
			if (step_total == 0)
				limit = (CNT_W+1)'(1);
			else if (step_total > MAX_STEPS)
				limit = (CNT_W+1)'(MAX_STEPS);
			else
				limit = (CNT_W+1)'(step_total);
			nxt = (CNT_W+1)'(cur_step) + (CNT_W+1)'(1);
			if (nxt >= limit) begin
				cur_step = '0;
				end_due  = 1'b1;
			end else begin
				cur_step = nxt[PTR_W-1:0];
			end
		endfunction

		function void check_key(kms_out_t got);
			kms_out_t want;
			if (keys_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected key word: key %h step %0d",
						got.send_key, got.step_number);
				return;
			end
			want = keys_due.pop_front();
			if (got.send_key !== want.send_key || got.step_number !== want.step_number) begin
				errors++;
				if (errors <= 10)
					$display("key word mismatch: expected key %h step %0d, got key %h step %0d",
						want.send_key, want.step_number, got.send_key, got.step_number);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	kms_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	kms_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	macro_player sb = new();

	int unsigned send_idle  = 0;
	int unsigned recv_stall = 0;
	bit          hold_req   = 1'b0;
	int          hold_left  = 0;
	int          cycles     = 0;

	// trigger as a user would drive it
	logic [31:0] cur_now;
	logic [31:0] cur_presses;
	logic        cur_down;

	key_macro_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10ns;
		clk = 1'b0;
		#10ns;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req || hold_left != 0) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end else begin
				hold_left--;
			end
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_key(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("key_macro_sequencer_test failed");
			$finish;
		end
	end

	function automatic kms_in_t noise_word();
		noise_word = IN_W'({$urandom, $urandom, $urandom});
	endfunction

	task automatic offer(input kms_in_t w);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.keys_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic tick_at(input logic [31:0] t, input logic down, input logic [31:0] cnt);
		kms_in_t w;
		w = noise_word();
		w.operation       = OP_TICK;
		w.now_ms          = t;
		w.trigger_down    = down;
		w.trigger_presses = cnt;
		offer(w);
	endtask

	task automatic load_step(input int slot, input logic [8:0] key, input logic [15:0] dly);
		kms_in_t w;
		w = noise_word();
		w.operation     = OP_LOAD;
		w.load_slot     = slot[PTR_W-1:0];
		w.load_key      = key;
		w.load_delay_ms = dly;
		offer(w);
	endtask

	task automatic random_word();
		kms_in_t     w;
		int unsigned r;
		int unsigned span;
		w = noise_word();
		if ($urandom_range(0, 99) < 8) begin
			w.operation = OP_LOAD;
			r = $urandom_range(0, 99);
			if (r < 85)
				w.load_delay_ms = 16'($urandom_range(0, 60));
			else if (r < 95)
				w.load_delay_ms = 16'($urandom_range(0, 1000));
			offer(w);
			return;
		end
		// time moves on about in step with the macro's own pace
		span = 40 + sb.press_len / 2;
		r = $urandom_range(0, 99);
		if (r < 85)
			cur_now += $urandom_range(0, span);
		else if (r < 95)
			cur_now += $urandom_range(0, span * 8);
		else if (r < 98)
			cur_now += $urandom;
		else
			cur_now = $urandom;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			cur_down = !cur_down;
			if (cur_down) begin
				cur_presses += 1;
				if (cur_presses == 0)
					cur_presses = 1;
			end
		end else if (r < 19) begin
			cur_presses = $urandom;
		end else if (r < 22) begin
			cur_presses += 1;
		end
		w.operation       = OP_TICK;
		w.now_ms          = cur_now;
		w.trigger_down    = cur_down;
		w.trigger_presses = cur_presses;
		offer(w);
	endtask

	initial begin
		logic [31:0] t0;
		int          ph;
		int          n;
		logic [15:0] press;
		logic        rep;
		logic [3:0]  cnt;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_PRESS_LENGTH, 16'd0);
		write_reg(REG_REPEAT_HELD, 16'd0);
		write_reg(REG_STEP_COUNT, 16'd3);
		write_reg(2'd3, 16'hFFFF);        // no such register

		load_step(0, 9'h1FF, 16'd0);
		load_step(1, 9'h000, 16'hFFFF);
		load_step(2, 9'h100, 16'd5);
		for (n = 3; n < MAX_STEPS; n++)
			load_step(n, 9'($urandom), 16'($urandom_range(1, 10)));

		// start near the wrap of the millisecond counter
		t0 = 32'hFFFF_FFF0;
		tick_at(t0, 1'b0, 32'd0);
		tick_at(t0, 1'b1, 32'd1);
		tick_at(t0, 1'b1, 32'd1);
		tick_at(t0 + 20, 1'b1, 32'd2);
		tick_at(t0 + 65535, 1'b1, 32'd2);
		tick_at(t0 + 65540, 1'b1, 32'd2);
		tick_at(t0 + 65540, 1'b1, 32'd2);
		tick_at(t0 + 131075, 1'b1, 32'd2);
		tick_at(t0 + 131080, 1'b0, 32'd2);
		tick_at(t0 + 131090, 1'b0, 32'hFFFF_FFFF);
		tick_at(t0 + 131090, 1'b1, 32'hFFFF_FFFF);
		tick_at(t0 + 200000, 1'b1, 32'hFFFF_FFFF);
		tick_at(t0 + 200010, 1'b1, 32'hFFFF_FFFF);
		cur_now     = t0 + 200010;
		cur_down    = 1'b1;
		cur_presses = 32'hFFFF_FFFF;

		for (ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin press = 16'd0;     rep = 1'b0; cnt = 4'd8;  end
				1: begin press = 16'hFFFF;  rep = 1'b1; cnt = 4'd8;  end
				2: begin press = 16'd20;    rep = 1'b1; cnt = 4'd0;  end
				3: begin press = 16'd7;     rep = 1'b0; cnt = 4'd15; end
				4: begin press = 16'd0;     rep = 1'b1; cnt = 4'd3;  end
				5: begin press = 16'd0;     rep = 1'b1; cnt = 4'd1;  end
				6: begin press = 16'($urandom_range(1, 300)); rep = 1'b0; cnt = 4'd5; end
				default: begin press = 16'd3; rep = 1'b1; cnt = 4'd8; end
			endcase
			write_reg(REG_PRESS_LENGTH, press);
			write_reg(REG_REPEAT_HELD, {15'($urandom), rep});
			write_reg(REG_STEP_COUNT, {12'($urandom), cnt});
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 58; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 58; end
				default: begin send_idle = 38; recv_stall = 38; end
			endcase

			if (ph == 4) begin
				// zero delays and a held trigger: a key word on every tick while
				// the output is held off, so the block backs up into its input
				for (n = 0; n < MAX_STEPS; n++)
					load_step(n, 9'($urandom), 16'd0);
				hold_req = 1'b1;
				cur_presses += 1;
				if (cur_presses == 0)
					cur_presses = 1;
				cur_down = 1'b1;
				for (n = 0; n < 40; n++)
					tick_at(cur_now, cur_down, cur_presses);
				drain();
			end

			for (n = 0; n < PHASE_WORDS; n++)
				random_word();
		end

		drain();
		if (sb.keys_due.size() != 0) begin
			sb.errors++;
			$display("%0d key words never came out", sb.keys_due.size());
		end
		if (sb.errors == 0)
			$display("key_macro_sequencer_test passed");
		else
			$display("key_macro_sequencer_test failed");
		$finish;
	end

endmodule
